@@ sv/spmr_pkg.sv @@
// ----------------------------------------------------------------------------
// spmr_pkg: shared constants and a helper for the shuffled Lehmer generator
// Holds the generator constants, field widths and the fraction conversion.
// ----------------------------------------------------------------------------
package spmr_pkg;

    // Field widths.
    localparam int VAL_W   = 31;
    localparam int FRAC_W  = 24;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = VAL_W + MULT_W;
    localparam int FRAC_SH = VAL_W - FRAC_W;

    // Minimal-standard generator constants.
    localparam logic [MULT_W-1:0] LEHMER_MULT = 15'd16807;
    localparam logic [VAL_W-1:0]  LEHMER_MOD  = 31'h7FFF_FFFF;
    localparam logic [FRAC_W-1:0] FRAC_MAX    = 24'd16777213;

    // Fraction floor(v * 2^24 / (2^31 - 1)), clamped just below one.
    // The quotient is either v >> 7 or one more; the remainder decides.
    function automatic logic [FRAC_W-1:0] frac_of(input logic [VAL_W-1:0] v);
        logic [FRAC_W-1:0] q0;
        logic [VAL_W-1:0]  r;
        logic [FRAC_W:0]   q;
        q0 = v[VAL_W-1:FRAC_SH];
        r  = {v[FRAC_SH-1:0], {FRAC_W{1'b0}}} + {{FRAC_SH{1'b0}}, q0};
        q  = {1'b0, q0} + {{FRAC_W{1'b0}}, (r == LEHMER_MOD)};
        if (q > {1'b0, FRAC_MAX})
        begin
            return FRAC_MAX;
        end
        return q[FRAC_W-1:0];
    endfunction

endpackage

@@ sv/shuffled_park_miller_rng_top.sv @@
// ----------------------------------------------------------------------------
// shuffled_park_miller_rng_top: Lehmer generator with a shuffle table
// Minimal-standard generator feeding a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Use: the seed port writes the seed register at any handshake; it takes
// effect at the next restart or at the first request after reset. Each item
// on the input channel (restart bit) yields one item on the output channel:
// a shuffled 31-bit integer and its 24-bit fraction.
// Rate: one item at a time. A normal draw runs the generator step in the
// shared two-stage multiply and fold unit, which hides the slot compare, then
// the registered table read, then the load of the output register. The input
// is ready again as the result appears. A reseeding request first runs
// TABLE_ENTRIES + WARMUP_EXTRA steps of the shared unit to warm up and fill
// the table.
// A stalled receiver holds the result in the output register, and the next
// draw waits at its last step until the register frees.
// Reset clears all control state and marks the generator unseeded; the
// seed register resets to 1 and the table needs no clearing.
// ----------------------------------------------------------------------------
module shuffled_park_miller_rng_top
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int WARMUP_EXTRA  = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [spmr_pkg::VAL_W-1:0]  seed,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        restart,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [spmr_pkg::VAL_W-1:0]  random_value,
    output logic [spmr_pkg::FRAC_W-1:0] fraction
);
    import spmr_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TOTAL = TABLE_ENTRIES + WARMUP_EXTRA;
    localparam int CNT_W = $clog2(TOTAL + 1);

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_WARM_GO,
        ST_WARM_WAIT,
        ST_DRAW_GO,
        ST_DRAW_WAIT,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t              state_reg, state_next;
    logic [VAL_W-1:0]    seed_reg, seed_next;
    logic [VAL_W-1:0]    x_reg, x_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [VAL_W-1:0]    gen_reg, gen_next;
    logic [VAL_W-1:0]    last_reg, last_next;
    logic                seeded_reg, seeded_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic                lgot_reg, lgot_next;
    logic                dgot_reg, dgot_next;
    logic                out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]    rv_reg, rv_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;

    logic [VAL_W-1:0]    table_mem [TABLE_ENTRIES];
    logic [VAL_W-1:0]    rd_data_reg;
    logic                rd_en;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [VAL_W-1:0]    wr_data;

    logic                l_start, l_done;
    logic [VAL_W-1:0]    l_operand, l_result;
    logic                d_start, d_done;
    logic [IDX_W-1:0]    d_slot;
    logic                out_free;

    // Shared multiply and fold unit.
    spmr_lehmer u_lehmer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (l_start),
        .operand (l_operand),
        .done    (l_done),
        .result  (l_result)
    );

    // Slot divider.
    spmr_slot_div #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_slot_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (d_start),
        .dividend (last_reg),
        .done     (d_done),
        .slot     (d_slot)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign l_start   = (state_reg == ST_WARM_GO) || (state_reg == ST_DRAW_GO);
    assign l_operand = (state_reg == ST_WARM_GO) ? x_reg : gen_reg;
    assign d_start   = (state_reg == ST_DRAW_GO);
    assign rd_en     = (state_reg == ST_READ);

    // Table writes: warm-up fill, or the fresh generator value after a draw.
    always_comb
    begin
        if (state_reg == ST_WARM_WAIT)
        begin
            wr_en   = l_done && (n_reg < CNT_W'(TABLE_ENTRIES));
            wr_addr = n_reg[IDX_W-1:0];
            wr_data = l_result;
        end
        else
        begin
            wr_en   = (state_reg == ST_LOAD) && out_free;
            wr_addr = slot_reg;
            wr_data = gen_reg;
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        gen_next       = gen_reg;
        last_next      = last_reg;
        seeded_next    = seeded_reg;
        slot_next      = slot_reg;
        lgot_next      = lgot_reg;
        dgot_next      = dgot_reg;
        out_valid_next = out_valid_reg;
        rv_next        = rv_reg;
        frac_next      = frac_reg;

        if (cfg_valid)
        begin
            seed_next = seed;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart || !seeded_reg)
                    begin
                        x_next     = (seed_reg == '0) ? VAL_W'(1) : seed_reg;
                        n_next     = CNT_W'(TOTAL - 1);
                        state_next = ST_WARM_GO;
                    end
                    else
                    begin
                        state_next = ST_DRAW_GO;
                    end
                end
            end
            ST_WARM_GO:
            begin
                state_next = ST_WARM_WAIT;
            end
            ST_WARM_WAIT:
            begin
                if (l_done)
                begin
                    x_next = l_result;
                    if (n_reg == '0)
                    begin
                        // The last step lands in slot 0 and is also the held output.
                        gen_next    = l_result;
                        last_next   = l_result;
                        seeded_next = 1'b1;
                        state_next  = ST_DRAW_GO;
                    end
                    else
                    begin
                        n_next     = n_reg - 1'b1;
                        state_next = ST_WARM_GO;
                    end
                end
            end
            ST_DRAW_GO:
            begin
                lgot_next  = 1'b0;
                dgot_next  = 1'b0;
                state_next = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT:
            begin
                if (l_done)
                begin
                    gen_next  = l_result;
                    lgot_next = 1'b1;
                end
                if (d_done)
                begin
                    slot_next = d_slot;
                    dgot_next = 1'b1;
                end
                if ((lgot_reg || l_done) && (dgot_reg || d_done))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    last_next      = rd_data_reg;
                    rv_next        = rd_data_reg;
                    frac_next      = frac_of(rd_data_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= VAL_W'(1);
            x_reg         <= '0;
            n_reg         <= '0;
            gen_reg       <= '0;
            last_reg      <= '0;
            seeded_reg    <= 1'b0;
            slot_reg      <= '0;
            lgot_reg      <= 1'b0;
            dgot_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rv_reg        <= '0;
            frac_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            x_reg         <= x_next;
            n_reg         <= n_next;
            gen_reg       <= gen_next;
            last_reg      <= last_next;
            seeded_reg    <= seeded_next;
            slot_reg      <= slot_next;
            lgot_reg      <= lgot_next;
            dgot_reg      <= dgot_next;
            out_valid_reg <= out_valid_next;
            rv_reg        <= rv_next;
            frac_reg      <= frac_next;
        end
    end

    // Shuffle table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[slot_reg];
        end
    end

    assign out_valid    = out_valid_reg;
    assign random_value = rv_reg;
    assign fraction     = frac_reg;

`ifndef SYNTHESIS
    // An accepted item blocks the input until its result is loaded.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted item");

    // A new result only appears out of the load step.
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_LOAD))
        else $error("output valid rose outside the load step");

    // The fraction never reaches one.
    a_frac_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fraction <= FRAC_MAX))
        else $error("fraction above its clamp");

    // The step unit always returns a reduced value.
    a_step_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        l_done |-> (l_result < LEHMER_MOD))
        else $error("generator step not reduced");
`endif

endmodule

@@ sv/spmr_lehmer.sv @@
// ----------------------------------------------------------------------------
// spmr_lehmer: one Lehmer step, x * 16807 mod (2^31 - 1)
// The first stage registers the product, the second folds it by the Mersenne modulus.
// ----------------------------------------------------------------------------
module spmr_lehmer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [spmr_pkg::VAL_W-1:0] operand,
    output logic                      done,
    output logic [spmr_pkg::VAL_W-1:0] result
);
    import spmr_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic              stage_reg;
    logic              done_reg;
    logic [VAL_W-1:0]  result_reg;
    logic [VAL_W:0]    fold_sum;
    logic [VAL_W-1:0]  fold_val;

    // Fold the high part back onto the low part; one subtract finishes it.
    always_comb
    begin
        fold_sum = {1'b0, prod_reg[VAL_W-1:0]}
                 + {{(VAL_W + 1 - MULT_W){1'b0}}, prod_reg[PROD_W-1:VAL_W]};
        if (fold_sum >= {1'b0, LEHMER_MOD})
        begin
            fold_val = VAL_W'(fold_sum - {1'b0, LEHMER_MOD});
        end
        else
        begin
            fold_val = fold_sum[VAL_W-1:0];
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    // Product and folded result.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(operand) * PROD_W'(LEHMER_MULT);
        end
        if (stage_reg)
        begin
            result_reg <= fold_val;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sv/spmr_slot_div.sv @@
// ----------------------------------------------------------------------------
// spmr_slot_div: table slot from the held output
// Compares against every slot boundary, registers the flags and encodes the highest.
// ----------------------------------------------------------------------------
module spmr_slot_div
#(
    parameter  int TABLE_ENTRIES = 32,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [spmr_pkg::VAL_W-1:0] dividend,
    output logic                       done,
    output logic [IDX_W-1:0]           slot
);
    import spmr_pkg::*;

    localparam logic [VAL_W-1:0] SLOT_DIV =
        VAL_W'(1 + (32'h7FFF_FFFE / TABLE_ENTRIES));

    logic [TABLE_ENTRIES-1:0] above_reg;
    logic [TABLE_ENTRIES-1:0] above_next;
    logic                     done_reg;

    // One compare per slot boundary; boundary k sits at k times the slot width.
    always_comb
    begin
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            above_next[k] = (64'(dividend) >= 64'(k) * 64'(SLOT_DIV));
        end
    end

    // The result is ready in the cycle after start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    // Registered boundary flags.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            above_reg <= above_next;
        end
    end

    // The highest boundary passed is the slot; only boundaries below the
    // last slot exist, so larger values land in the last slot.
    always_comb
    begin
        slot = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (above_reg[k])
            begin
                slot = IDX_W'(k);
            end
        end
    end

    assign done = done_reg;

endmodule
